### src/rgbh_pkg.sv
package rgbh_pkg;

  localparam int unsigned COUNT_BITS_DEF = 20;
  localparam int unsigned BIN_BITS       = 8;
  localparam int unsigned NUM_BINS       = 1 << BIN_BITS;
  localparam int unsigned OUT_BITS       = 20;
  localparam int unsigned NUM_CH         = 4;
  localparam int unsigned CH_BITS        = 2;
  localparam int unsigned LUMA_BITS      = BIN_BITS + 5;

  // channel codes, same as the read_channel encoding
  localparam logic [CH_BITS-1:0] CH_GRAY  = 2'd0;
  localparam logic [CH_BITS-1:0] CH_RED   = 2'd1;
  localparam logic [CH_BITS-1:0] CH_GREEN = 2'd2;
  localparam logic [CH_BITS-1:0] CH_BLUE  = 2'd3;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_READ  = 1'b1;

endpackage

### src/rgb_gray_histogram_with_max_top.sv
// a request is taken only while idle; the bin words it addresses are read into registers
// on accept, and once the output is free the update is written back to the bin memories
// and the result is registered, with no new request taken before that
// reset: rst_ni clears control state and both peaks, then a clearing pass
// zeroes every bin of the four memories while the input is stalled
module rgb_gray_histogram_with_max_top #(
  parameter int unsigned COUNT_BITS = rgbh_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           req_type_i,
  input  logic [rgbh_pkg::BIN_BITS-1:0]  red_i,
  input  logic [rgbh_pkg::BIN_BITS-1:0]  green_i,
  input  logic [rgbh_pkg::BIN_BITS-1:0]  blue_i,
  input  logic [rgbh_pkg::CH_BITS-1:0]   read_channel_i,
  input  logic [rgbh_pkg::BIN_BITS-1:0]  read_bin_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [rgbh_pkg::OUT_BITS-1:0]  bin_count_o,
  output logic [rgbh_pkg::OUT_BITS-1:0]  max_color_o,
  output logic [rgbh_pkg::OUT_BITS-1:0]  max_gray_o
);

  localparam int unsigned NCH = rgbh_pkg::NUM_CH;
  localparam int unsigned BW  = rgbh_pkg::BIN_BITS;
  localparam int unsigned LW  = rgbh_pkg::LUMA_BITS;
  localparam int unsigned OW  = rgbh_pkg::OUT_BITS;

  function automatic logic [OW-1:0] fit_out(input logic [COUNT_BITS-1:0] v);
    logic [OW+COUNT_BITS-1:0] w;
    w = {{OW{1'b0}}, v};
    return w[OW-1:0];
  endfunction

  logic                      in_accept;
  logic                      busy_q;
  logic                      clr_q;
  logic [BW-1:0]             clr_addr_q;
  logic                      done;
  logic                      wr_en;
  logic                      req_q;
  logic [rgbh_pkg::CH_BITS-1:0] ch_q;
  logic [BW-1:0]             rd_addr [NCH];
  logic [BW-1:0]             addr_q  [NCH];
  logic [COUNT_BITS-1:0]     cur     [NCH];
  logic [COUNT_BITS-1:0]     inc     [NCH];
  logic [COUNT_BITS-1:0]     count_max;
  logic [COUNT_BITS-1:0]     color_peak_q, color_peak_d;
  logic [COUNT_BITS-1:0]     gray_peak_q, gray_peak_d;
  logic [COUNT_BITS-1:0]     bin_cnt_d;
  logic [LW-1:0]             luma_sum;
  logic [BW-1:0]             luma;
  logic                      out_valid_q;
  logic [OW-1:0]             bin_count_q, max_color_q, max_gray_q;

  assign count_max  = '1;
  assign in_stall_o = busy_q || clr_q;
  assign in_accept  = in_valid_i && !busy_q && !clr_q;
  assign done       = busy_q && (!out_valid_q || !out_stall_i);
  assign wr_en      = done && (req_q == rgbh_pkg::REQ_PIXEL);

  // gray = (11r + 16g + 5b) / 32
  assign luma_sum = LW'(red_i) * LW'(11) + (LW'(green_i) << 4) + LW'(blue_i) * LW'(5);
  assign luma     = luma_sum[LW-1:5];

  always_comb begin
    if (req_type_i == rgbh_pkg::REQ_READ) begin
      for (int i = 0; i < NCH; i++) rd_addr[i] = read_bin_i;
    end else begin
      rd_addr[rgbh_pkg::CH_GRAY]  = luma;
      rd_addr[rgbh_pkg::CH_RED]   = red_i;
      rd_addr[rgbh_pkg::CH_GREEN] = green_i;
      rd_addr[rgbh_pkg::CH_BLUE]  = blue_i;
    end
  end

  for (genvar g = 0; g < NCH; g++) begin : g_store
    logic [COUNT_BITS-1:0]         mem_r [rgbh_pkg::NUM_BINS];
    logic [COUNT_BITS-1:0]         rd_q;

    always_ff @(posedge clk_i) begin
      if (in_accept) begin
        rd_q <= mem_r[rd_addr[g]];
      end
      if (clr_q) begin
        mem_r[clr_addr_q] <= '0;
      end else if (wr_en) begin
        mem_r[addr_q[g]] <= inc[g];
      end
    end

    assign cur[g] = rd_q;
    assign inc[g] = (cur[g] == count_max) ? cur[g] : cur[g] + COUNT_BITS'(1);
  end

  always_comb begin
    color_peak_d = color_peak_q;
    gray_peak_d  = gray_peak_q;
    if (req_q == rgbh_pkg::REQ_PIXEL) begin
      if (inc[rgbh_pkg::CH_RED] > color_peak_d) color_peak_d = inc[rgbh_pkg::CH_RED];
      if (inc[rgbh_pkg::CH_GREEN] > color_peak_d) color_peak_d = inc[rgbh_pkg::CH_GREEN];
      if (inc[rgbh_pkg::CH_BLUE] > color_peak_d) color_peak_d = inc[rgbh_pkg::CH_BLUE];
      if (inc[rgbh_pkg::CH_GRAY] > gray_peak_d) gray_peak_d = inc[rgbh_pkg::CH_GRAY];
    end
    bin_cnt_d = (req_q == rgbh_pkg::REQ_READ) ? cur[ch_q] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q  <= req_type_i;
      ch_q   <= read_channel_i;
      addr_q <= rd_addr;
    end
    if (done) begin
      bin_count_q <= fit_out(bin_cnt_d);
      max_color_q <= fit_out(color_peak_d);
      max_gray_q  <= fit_out(gray_peak_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      clr_q        <= 1'b1;
      clr_addr_q   <= '0;
      out_valid_q  <= 1'b0;
      color_peak_q <= '0;
      gray_peak_q  <= '0;
    end else begin
      // walk every bin once after reset
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + BW'(1);
        if (clr_addr_q == '1) begin
          clr_q <= 1'b0;
        end
      end
      if (in_accept) begin
        busy_q <= 1'b1;
      end else if (done) begin
        busy_q <= 1'b0;
      end
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (wr_en) begin
        color_peak_q <= color_peak_d;
        gray_peak_q  <= gray_peak_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign bin_count_o = bin_count_q;
  assign max_color_o = max_color_q;
  assign max_gray_o  = max_gray_q;

  a_color_peak_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> color_peak_q >= $past(color_peak_q))
    else $error("color peak decreased");

  a_gray_peak_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> gray_peak_q >= $past(gray_peak_q))
    else $error("gray peak decreased");

  a_done_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> out_valid_q && !busy_q)
    else $error("finished request not presented");

  a_read_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> busy_q && req_q == rgbh_pkg::REQ_PIXEL)
    else $error("store written outside a pixel update");

  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> in_stall_o && !busy_q)
    else $error("request taken during the clearing pass");

endmodule
